// ----- hw/rtl/gacn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gacn_pkg;

  localparam int NODES           = 64;
  localparam int MAX_DEGREE      = 16;
  localparam int MAX_QUERY_NODES = 4;

  localparam int NODE_W  = 6;
  localparam int CNT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LIST_AW = NODE_W + IDX_W;
  localparam int QLIM    = (MAX_QUERY_NODES < 4) ? MAX_QUERY_NODES : 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_SELF    = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [NODES-1:0] bits;
  } row_t;

endpackage

`default_nettype wire

// ----- hw/rtl/graph_adjacency_common_neighbours_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Undirected graph store with common-neighbour queries. Each node has a row
// in a synchronous row memory (adjacency bits plus list length, cleared at
// reset by per-row valid flops) and a neighbour list in a second memory
// (entries undefined until written, never read past the list length). One
// request is processed at a time. An add reads both rows through the single
// row read port, then writes them back one after the other, giving its result
// with the second write. A self edge or a full list writes nothing and
// answers ST_SELF or ST_FULL. A query first reads the first node's row for
// the length. It then walks one candidate per cycle, while the output is not
// stalled, through a two-stage list-read / row-read pipeline. Adjacency is
// symmetric, so the candidate's own row is checked against the filters. The
// walk covers len list entries, at most MAX_DEGREE. An empty list or no
// match answers ST_NOMATCH. A result that waits on out_tready stalls the
// state machine. No clearing pass is needed.
module graph_adjacency_common_neighbours_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // node_a[5:0], node_b[11:6], node_c[17:12], node_d[23:18], node_count[26:24]
  input  wire  [gacn_pkg::IN_DATA_W-1:0]       in_tdata,
  // req_type[0]
  input  wire                                  in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // neighbour[5:0]
  output logic [gacn_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status[1:0]
  output logic [gacn_pkg::STAT_W-1:0]          out_tuser,
  output logic                                 out_tlast
);

  import gacn_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD_A  = 6'b000010,
    S_ADD_B  = 6'b000100,
    S_ADD_W  = 6'b001000,
    S_Q_LEN  = 6'b010000,
    S_Q_WALK = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // request
  logic [NODE_W-1:0] a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  in_cnt, cnt_eff;

  // row memory
  row_t              row_mem [NODES];
  logic [NODES-1:0]  row_vld_r;
  row_t              row_q_r;
  logic              row_qv_r;
  row_t              row_eff;
  logic              row_re, row_we;
  logic [NODE_W-1:0] row_ra, row_wa;
  row_t              row_wd;
  row_t              rowa_r, rowa_nxt;

  // neighbour list memory
  logic [NODE_W-1:0] list_mem [2**LIST_AW];
  logic [NODE_W-1:0] list_q_r;
  logic              list_re, list_we;
  logic [LIST_AW-1:0] list_ra, list_wa;
  logic [NODE_W-1:0] list_wd;

  // query walk
  logic [LEN_W-1:0]  len_r, len_nxt, iss_r, iss_nxt;
  logic              s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic [NODE_W-1:0] cand2_r, cand2_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [NODE_W-1:0] pend_nb_r, pend_nb_nxt;
  logic              match, reject, filt_oob;
  logic [LEN_W-1:0]  row_len_clip;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_nb_r, out_nb_nxt;
  status_t           out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;
  logic              slot_free, push, push_last;
  logic [NODE_W-1:0] push_nb;
  status_t           push_st;

  assign in_cnt  = in_tdata[26:24];
  assign cnt_eff = (in_cnt == '0) ? CNT_W'(1) :
                   ((int'(in_cnt) > QLIM) ? CNT_W'(QLIM) : in_cnt);

  assign row_eff   = row_qv_r ? row_q_r : '0;
  assign slot_free = !out_valid_r || out_tready;

  assign filt_oob = (int'(a_r) >= NODES) ||
                    (cnt_r >= CNT_W'(2) && int'(b_r) >= NODES) ||
                    (cnt_r >= CNT_W'(3) && int'(c_r) >= NODES) ||
                    (cnt_r >= CNT_W'(4) && int'(d_r) >= NODES);

  assign row_len_clip = (int'(row_eff.len) > MAX_DEGREE) ? LEN_W'(MAX_DEGREE) : row_eff.len;

  assign reject = (a_r == b_r) || (int'(a_r) >= NODES) || (int'(b_r) >= NODES) ||
                  (int'(rowa_r.len) >= MAX_DEGREE) || (int'(row_eff.len) >= MAX_DEGREE);

  assign match = (cnt_r < CNT_W'(2) || row_eff.bits[b_r]) &&
                 (cnt_r < CNT_W'(3) || row_eff.bits[c_r]) &&
                 (cnt_r < CNT_W'(4) || row_eff.bits[d_r]);

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    d_nxt       = d_r;
    cnt_nxt     = cnt_r;
    rowa_nxt    = rowa_r;
    row_re      = 1'b0;
    row_ra      = a_r;
    row_we      = 1'b0;
    row_wa      = a_r;
    row_wd      = rowa_r;
    list_re     = 1'b0;
    list_ra     = {a_r, iss_r[IDX_W-1:0]};
    list_we     = 1'b0;
    list_wa     = {a_r, rowa_r.len[IDX_W-1:0]};
    list_wd     = b_r;
    len_nxt     = len_r;
    iss_nxt     = iss_r;
    s1_v_nxt    = s1_v_r;
    s2_v_nxt    = s2_v_r;
    cand2_nxt   = cand2_r;
    pend_v_nxt  = pend_v_r;
    pend_nb_nxt = pend_nb_r;
    push        = 1'b0;
    push_nb     = '0;
    push_st     = ST_OK;
    push_last   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          a_nxt   = in_tdata[5:0];
          b_nxt   = in_tdata[11:6];
          c_nxt   = in_tdata[17:12];
          d_nxt   = in_tdata[23:18];
          cnt_nxt = cnt_eff;
          row_re  = 1'b1;
          row_ra  = in_tdata[5:0];
          state_nxt = (in_tuser == REQ_ADD) ? S_ADD_A : S_Q_LEN;
        end
      end
      S_ADD_A: begin
        rowa_nxt  = row_eff;
        row_re    = 1'b1;
        row_ra    = b_r;
        state_nxt = S_ADD_B;
      end
      S_ADD_B: begin
        if (reject) begin
          if (slot_free) begin
            push      = 1'b1;
            push_st   = (a_r == b_r) ? ST_SELF : ST_FULL;
            push_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          row_we           = 1'b1;
          row_wa           = b_r;
          row_wd.len       = row_eff.len + LEN_W'(1);
          row_wd.bits      = row_eff.bits;
          row_wd.bits[a_r] = 1'b1;
          list_we          = 1'b1;
          list_wa          = {b_r, row_eff.len[IDX_W-1:0]};
          list_wd          = a_r;
          state_nxt        = S_ADD_W;
        end
      end
      S_ADD_W: begin
        if (slot_free) begin
          row_we           = 1'b1;
          row_wa           = a_r;
          row_wd.len       = rowa_r.len + LEN_W'(1);
          row_wd.bits      = rowa_r.bits;
          row_wd.bits[b_r] = 1'b1;
          list_we          = 1'b1;
          push             = 1'b1;
          push_st          = ST_OK;
          push_last        = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_Q_LEN: begin
        len_nxt    = filt_oob ? '0 : row_len_clip;
        iss_nxt    = '0;
        s1_v_nxt   = 1'b0;
        s2_v_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
        state_nxt  = S_Q_WALK;
      end
      S_Q_WALK: begin
        if (slot_free) begin
          // stage 2: filter check on candidate row
          if (s2_v_r && match) begin
            if (pend_v_r) begin
              push    = 1'b1;
              push_nb = pend_nb_r;
              push_st = ST_OK;
            end
            pend_v_nxt  = 1'b1;
            pend_nb_nxt = cand2_r;
          end
          // stage 1: candidate row read
          s2_v_nxt = s1_v_r;
          if (s1_v_r) begin
            row_re    = 1'b1;
            row_ra    = list_q_r;
            cand2_nxt = list_q_r;
          end
          // stage 0: list read
          s1_v_nxt = (iss_r < len_r);
          if (iss_r < len_r) begin
            list_re = 1'b1;
            iss_nxt = iss_r + LEN_W'(1);
          end
          if (iss_r == len_r && !s1_v_r && !s2_v_r) begin
            push       = 1'b1;
            push_nb    = pend_v_r ? pend_nb_r : '0;
            push_st    = pend_v_r ? ST_OK : ST_NOMATCH;
            push_last  = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nb_nxt    = out_nb_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nb_nxt    = push_nb;
      out_st_nxt    = push_st;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      len_r       <= len_nxt;
      if (row_we) begin
        row_vld_r[row_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    c_r       <= c_nxt;
    d_r       <= d_nxt;
    cnt_r     <= cnt_nxt;
    rowa_r    <= rowa_nxt;
    cand2_r   <= cand2_nxt;
    pend_nb_r <= pend_nb_nxt;
    out_nb_r  <= out_nb_nxt;
    out_st_r  <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  // row memory: valid flag read alongside data
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (row_re) begin
      row_q_r  <= row_mem[row_ra];
      row_qv_r <= row_vld_r[row_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    if (list_re) begin
      list_q_r <= list_mem[list_ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_nb_r);
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!s1_v_r && !s2_v_r && !pend_v_r))
    else $error("item accepted while query pipeline busy");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r == S_Q_WALK))
    else $error("pending match outside query walk");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_WALK) |-> (iss_r <= len_r && int'(len_r) <= MAX_DEGREE))
    else $error("list walk past length");

  a_row_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (int'(row_wd.len) <= MAX_DEGREE))
    else $error("row length overflow");

  a_no_push_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_nb_r)))
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire
